[design/tlfo_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlfo_pkg: shared types and codes of the tremulant LFO modulator
// Payload structs of the request, response and internal queue, the
// configuration register image, register indexes and item codes.
// ----------------------------------------------------------------------------
package tlfo_pkg;

   // Field widths fixed by the interface
   localparam int FRAME_FIELD_W = 16;
   localparam int PHASE_W       = 32;
   localparam int DEPTH_W       = 20;
   localparam int PRESSURE_W    = 21;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 32;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_STEP   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH_TARGET = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAVE_SELECT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE       = 2'd3;

   // Item kinds
   localparam logic ACT_ADVANCE = 1'b0;
   localparam logic ACT_QUERY   = 1'b1;

   // Waveform codes
   localparam logic [1:0] WAVE_SINE = 2'd0;
   localparam logic [1:0] WAVE_TRI  = 2'd1;
   localparam logic [1:0] WAVE_SAW  = 2'd2;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic                     action;
      logic [FRAME_FIELD_W-1:0] frame_number;
   } req_type;

   typedef struct packed {
      logic signed [PRESSURE_W-1:0] pressure_delta;
      logic [PHASE_W-1:0]           phase_now;
   } rsp_type;

   typedef struct packed {
      logic                     action;
      logic [FRAME_FIELD_W-1:0] frames;
   } qent_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase_step;
      logic [DEPTH_W-1:0] depth_target;
      logic [1:0]         waveform_select;
      logic               enable;
   } cfg_type;

endpackage
`default_nettype wire

[design/tlfo_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlfo_front: request intake of the tremulant LFO modulator
// Accepts items, trims the frame count to the frame width and holds them
// in a short queue until the execution back end takes them.
// ----------------------------------------------------------------------------
module tlfo_front #(
   parameter int FRAME_BITS = 16
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  tlfo_pkg::req_type  req_data,
   output logic               q_valid,
   output tlfo_pkg::qent_type q_data,
   input  wire                q_pop
);

   localparam int FW = (FRAME_BITS < tlfo_pkg::FRAME_FIELD_W) ?
                       FRAME_BITS : tlfo_pkg::FRAME_FIELD_W;
   localparam logic [tlfo_pkg::FRAME_FIELD_W-1:0] FRAME_MASK =
      {tlfo_pkg::FRAME_FIELD_W{1'b1}} >> (tlfo_pkg::FRAME_FIELD_W - FW);

   tlfo_pkg::qent_type                q_mem [tlfo_pkg::QUEUE_DEPTH];
   logic [tlfo_pkg::QPTR_W-1:0]       wr_ff, wr_in, rd_ff, rd_in;
   logic [tlfo_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                              push;
   tlfo_pkg::qent_type                entry;

   // Classify and trim the incoming item
   always_comb begin
      entry.action = req_data.action;
      entry.frames = req_data.frame_number & FRAME_MASK;
   end

   assign req_ready = (count_ff != tlfo_pkg::QCNT_W'(tlfo_pkg::QUEUE_DEPTH));
   assign push      = req_valid & req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_data    = q_mem[rd_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == tlfo_pkg::QPTR_W'(tlfo_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_in = (rd_ff == tlfo_pkg::QPTR_W'(tlfo_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Store the item
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ff] <= entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= tlfo_pkg::QCNT_W'(tlfo_pkg::QUEUE_DEPTH))
      else $error("queue occupancy above depth");

   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      (push && count_ff == '0) |=> q_valid)
      else $error("item pushed into empty queue not visible");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("item popped from empty queue");

endmodule
`default_nettype wire

[design/tlfo_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlfo_back: execution back end of the tremulant LFO modulator
// Holds the phase accumulator and ramp state, runs advance items in one
// step and query items through phase, wave, lookup, mag and two multiplies.
// ----------------------------------------------------------------------------
module tlfo_back #(
   parameter int SINE_TABLE_DEPTH = 256
) (
   input  wire                clock,
   input  wire                reset,
   input  tlfo_pkg::cfg_type  cfg,
   input  wire                q_valid,
   input  tlfo_pkg::qent_type q_data,
   output logic               q_pop,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output tlfo_pkg::rsp_type  rsp_data
);

   localparam int          IW           = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int          PW           = 30 + IW;
   localparam logic [63:0] TBL_DEPTH64  = 64'(SINE_TABLE_DEPTH);
   localparam logic [16:0] GAIN_ONE     = 17'h10000;
   localparam logic [17:0] SAW_RECIP    = 18'd174763;
   localparam logic [19:0] PRESSURE_MAX = 20'hFFFFF;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_WAVE = 7'b0000010,
      ST_LOOK = 7'b0000100,
      ST_MAG  = 7'b0001000,
      ST_MUL1 = 7'b0010000,
      ST_MUL2 = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   // Quarter-wave sine entry, built at elaboration from a Taylor series
   function automatic logic [14:0] sine_entry(input int unsigned i);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic signed [63:0] v;
      x    = (64'd1686629713 * 64'(i) + (TBL_DEPTH64 >> 1)) / TBL_DEPTH64;
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      term = ((term * x2) >> 30) / 64'd6;   sum = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd20;  sum = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd42;  sum = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd72;  sum = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd110; sum = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd156; sum = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd210; sum = sum - signed'(term);
      if (sum < 0) begin
         sum = '0;
      end
      v = (sum * 64'sd32767 + 64'sd536870912) >>> 30;
      if (v > 64'sd32767) begin
         v = 64'sd32767;
      end
      return v[14:0];
   endfunction

   // Move a level a quarter of the way to its target, at least one LSB
   function automatic logic [19:0] ramp_step(input logic [19:0] level,
                                             input logic [19:0] target);
      logic [19:0] d;
      logic [19:0] s;
      d = (level < target) ? target - level : level - target;
      s = d >> 2;
      if (s == '0) begin
         s = 20'd1;
      end
      if (level == target) begin
         return level;
      end
      return (level < target) ? level + s : level - s;
   endfunction

   logic [14:0] sine_rom [SINE_TABLE_DEPTH + 1];

   for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_sine
      assign sine_rom[g] = sine_entry(g);
   end

   // Control and architectural state
   state_type    st_ff, st_in;
   logic [31:0]  acc_ff, bsp_ff, latched_ff;
   logic [16:0]  gain_ff, gain_in;
   logic [19:0]  depth_ff, depth_in;
   logic         rsp_valid_ff, rsp_valid_in;

   // Datapath registers
   logic              qry_ff;
   logic [31:0]       ph_ff;
   logic [IW-1:0]     idx_ff;
   logic              sneg_ff;
   logic signed [17:0] tw_ff;
   logic              hi_ff;
   logic [17:0]       n_ff;
   logic [14:0]       rom_ff;
   logic signed [17:0] pw_ff;
   logic [15:0]       mag_ff;
   logic              neg_ff;
   logic [35:0]       p1_ff;
   logic [52:0]       p2_ff;
   tlfo_pkg::rsp_type rsp_data_ff;

   logic [31:0]        mul_a, step_prod;
   logic [PW-1:0]      idx_prod;
   logic [IW-1:0]      idx_raw, idx_in;
   logic signed [17:0] tri_w, sawlo_w;
   logic [31:0]        saw_sum;
   logic [35:0]        q_prod;
   logic [16:0]        saw_q;
   logic signed [17:0] w_sel;
   logic [17:0]        w_abs;
   logic [52:0]        rnd;
   logic [21:0]        r_full;
   logic [19:0]        r_sat;
   logic signed [20:0] delta;
   logic               load_out;

   assign q_pop    = (st_ff == ST_IDLE) && q_valid;
   assign load_out = (st_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // Shared step times frame count product
   always_comb begin
      mul_a     = (q_data.action == tlfo_pkg::ACT_QUERY) ? latched_ff : cfg.phase_step;
      step_prod = mul_a * 32'(q_data.frames);
      gain_in   = 17'(ramp_step(20'(gain_ff), cfg.enable ? 20'(GAIN_ONE) : 20'd0));
      depth_in  = ramp_step(depth_ff, cfg.depth_target);
   end

   // Wave front stage: sine index, triangle, saw pieces
   always_comb begin
      idx_prod = PW'(ph_ff[29:0]) * PW'(SINE_TABLE_DEPTH) + PW'(32'h2000_0000);
      idx_raw  = idx_prod[PW-1:30];
      idx_in   = ph_ff[30] ? IW'(SINE_TABLE_DEPTH) - idx_raw : idx_raw;
      tri_w    = ph_ff[31] ? 18'sd98304 - signed'({1'b0, ph_ff[31:15]})
                           : signed'({1'b0, ph_ff[31:15]}) - 18'sd32768;
      sawlo_w  = signed'({2'b00, ph_ff[29:14]}) - 18'sd32768;
      saw_sum  = ph_ff - 32'h4000_0000 + 32'd24576;
   end

   // Divide the saw numerator by three through a reciprocal
   always_comb begin
      q_prod = 36'(n_ff) * 36'(SAW_RECIP);
      saw_q  = q_prod[35:19];
   end

   // Pick the wave, saturate and split into sign and magnitude
   always_comb begin
      unique case (cfg.waveform_select)
         tlfo_pkg::WAVE_SINE: begin
            w_sel = sneg_ff ? -signed'({3'b000, rom_ff}) : signed'({3'b000, rom_ff});
         end
         tlfo_pkg::WAVE_TRI, tlfo_pkg::WAVE_SAW: begin
            w_sel = (pw_ff > 18'sd32767) ? 18'sd32767 : pw_ff;
         end
         default: begin
            w_sel = '0;
         end
      endcase
      w_abs = w_sel[17] ? 18'(-w_sel) : 18'(w_sel);
   end

   // Round, saturate and sign the scaled result; zero for an advance item
   always_comb begin
      rnd    = p2_ff + 53'h4000_0000;
      r_full = rnd[52:31];
      r_sat  = (r_full > 22'(PRESSURE_MAX)) ? PRESSURE_MAX : r_full[19:0];
      if (!qry_ff) begin
         delta = '0;
      end else if (neg_ff) begin
         delta = -signed'({1'b0, r_sat});
      end else begin
         delta = signed'({1'b0, r_sat});
      end
   end

   // Sequence one item at a time
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               st_in = (q_data.action == tlfo_pkg::ACT_QUERY) ? ST_WAVE : ST_DONE;
            end
         end
         ST_WAVE: st_in = ST_LOOK;
         ST_LOOK: st_in = ST_MAG;
         ST_MAG:  st_in = ST_MUL1;
         ST_MUL1: st_in = ST_MUL2;
         ST_MUL2: st_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         acc_ff       <= '0;
         bsp_ff       <= '0;
         latched_ff   <= '0;
         gain_ff      <= '0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop && q_data.action == tlfo_pkg::ACT_ADVANCE) begin
            bsp_ff     <= acc_ff;
            latched_ff <= cfg.phase_step;
            acc_ff     <= acc_ff + step_prod;
            gain_ff    <= gain_in;
            depth_ff   <= depth_in;
         end
      end
   end

   // Datapath stages
   always_ff @(posedge clock) begin
      if (q_pop) begin
         qry_ff <= (q_data.action == tlfo_pkg::ACT_QUERY);
         ph_ff  <= bsp_ff + step_prod;
      end
      if (st_ff == ST_WAVE) begin
         idx_ff  <= idx_in;
         sneg_ff <= ph_ff[31];
         tw_ff   <= (cfg.waveform_select == tlfo_pkg::WAVE_TRI) ? tri_w : sawlo_w;
         hi_ff   <= (cfg.waveform_select == tlfo_pkg::WAVE_SAW) && (ph_ff[31:30] != 2'b00);
         n_ff    <= saw_sum[31:14];
      end
      if (st_ff == ST_LOOK) begin
         rom_ff <= sine_rom[idx_ff];
         pw_ff  <= hi_ff ? 18'sd32768 - signed'({1'b0, saw_q}) : tw_ff;
      end
      if (st_ff == ST_MAG) begin
         mag_ff <= w_abs[15:0];
         neg_ff <= w_sel[17];
      end
      if (st_ff == ST_MUL1) begin
         p1_ff <= 36'(depth_ff) * 36'(mag_ff);
      end
      if (st_ff == ST_MUL2) begin
         p2_ff <= 53'(p1_ff) * 53'(gain_ff);
      end
      if (load_out) begin
         rsp_data_ff.pressure_delta <= delta;
         rsp_data_ff.phase_now      <= acc_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_gain_bound: assert property (@(posedge clock) disable iff (reset)
      gain_ff <= GAIN_ONE)
      else $error("gain ramp overshot one");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(st_ff == ST_DONE))
      else $error("response raised outside completion step");

   a_advance_short: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_data.action == tlfo_pkg::ACT_ADVANCE) |=> (st_ff == ST_DONE))
      else $error("advance item did not complete in one step");

endmodule
`default_nettype wire

[design/tremulant_lfo_modulator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tremulant_lfo_modulator: low-frequency pressure modulator, top level
// Items enter on req_*, one result per item leaves on rsp_*; settings are
// written on csr_* (index 0 phase step, 1 depth target, 2 waveform,
// 3 enable); the user must write them only while no item is in flight,
// which the block itself does not enforce. csr_ready is always high.
// An advance item (action 0) moves the phase by step times frame count,
// ramps gain and depth, and returns zero pressure. A query item (action 1)
// returns depth * wave * gain at the block-start phase plus step times frame.
// The execution sequencer runs one item at a time through its wave lookup
// and two registered multiplies; it takes the next item once the last is done.
// A 2-entry queue keeps taking requests while the back end works or the
// response waits. When rsp_ready is low the response register holds and the
// back end stops after its current item; requests stall once the queue fills.
// Reset clears phase, gain, depth and all settings; the block is ready at
// the first cycle after reset.
// ----------------------------------------------------------------------------
module tremulant_lfo_modulator #(
   parameter int FRAME_BITS       = 16,
   parameter int SINE_TABLE_DEPTH = 256
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  tlfo_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output tlfo_pkg::rsp_type                   rsp_data,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire [tlfo_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire [tlfo_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   tlfo_pkg::cfg_type  cfg_ff;
   tlfo_pkg::qent_type q_data;
   logic               q_valid;
   logic               q_pop;

   assign csr_ready = 1'b1;

   // Write settings
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tlfo_pkg::CSR_PHASE_STEP:   cfg_ff.phase_step      <= csr_wdata;
            tlfo_pkg::CSR_DEPTH_TARGET: cfg_ff.depth_target    <= csr_wdata[tlfo_pkg::DEPTH_W-1:0];
            tlfo_pkg::CSR_WAVE_SELECT:  cfg_ff.waveform_select <= csr_wdata[1:0];
            tlfo_pkg::CSR_ENABLE:       cfg_ff.enable          <= csr_wdata[0];
            default:                    cfg_ff                 <= cfg_ff;
         endcase
      end
   end

   tlfo_front #(
      .FRAME_BITS (FRAME_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop)
   );

   tlfo_back #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

[test/tremulant_lfo_modulator_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tremulant_lfo_modulator_checker: response checker of the tremulant LFO
// Watches the request, response and register channels, keeps its own copy
// of the phase accumulator, gain and depth ramps and settings, predicts
// every response and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module tremulant_lfo_modulator_checker
   import tlfo_pkg::*;
#(
   parameter int FRAME_BITS       = 16,
   parameter int SINE_TABLE_DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    failures,
   output int                    pending
);

   localparam logic [31:0]     GAIN_ONE    = 32'd65536;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam logic [31:0]     FRAME_MASK  = (32'd1 << FRAME_BITS) - 32'd1;

   // Settings as last written
   logic [31:0] step_reg;
   logic [19:0] depth_goal;
   logic [1:0]  wave_reg;
   logic        enable_reg;

   // Modulator state
   logic [31:0] acc_phase;
   logic [31:0] block_phase;
   logic [31:0] block_step;
   logic [16:0] gain_q16;
   logic [19:0] depth_q8;

   int      sine_lut[0:SINE_TABLE_DEPTH];
   rsp_type expected_results[$];
   int      error_count   = 0;
   int      items_taken   = 0;
   int      results_taken = 0;

   assign failures = error_count;
   assign pending  = items_taken - results_taken;

   // Build the quarter-wave sine table with a fixed-point Taylor series
   initial begin : build_sine_lut
      longint unsigned x, x2, term;
      longint          sum, v;
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         x    = (HALF_PI_Q30 * i + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
         x2   = (x * x) >> 30;
         term = x;
         sum  = longint'(x);
         for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
            if (k % 2 == 1) sum -= longint'(term);
            else sum += longint'(term);
         end
         if (sum < 0) sum = 0;
         v = (sum * 32767 + (64'sd1 <<< 29)) / (64'sd1 <<< 30);
         if (v > 32767) v = 32767;
         sine_lut[i] = int'(v);
      end
   end

   // Move a level a quarter of the way to its target, at least one step
   function automatic logic [31:0] ramp_toward(logic [31:0] level, logic [31:0] target);
      logic [31:0] gap, stride;
      if (level == target) return level;
      gap    = (level < target) ? target - level : level - target;
      stride = gap >> 2;
      if (stride == 0) stride = 32'd1;
      return (level < target) ? level + stride : level - stride;
   endfunction

   // Apply one item to the modulator state and return its response
   function automatic rsp_type modulate_item(req_type item);
      rsp_type         result;
      logic [31:0]     frames, ph, saw_off;
      longint unsigned idx, mag, scaled;
      logic [20:0]     mag21;
      int              w;
      frames = 32'(item.frame_number) & FRAME_MASK;
      result.pressure_delta = '0;
      if (item.action == ACT_ADVANCE) begin
         block_phase = acc_phase;
         block_step  = step_reg;
         acc_phase   = acc_phase + step_reg * frames;
         gain_q16    = 17'(ramp_toward(32'(gain_q16), enable_reg ? GAIN_ONE : 32'd0));
         depth_q8    = 20'(ramp_toward(32'(depth_q8), 32'(depth_goal)));
      end else if (gain_q16 != 0 && depth_q8 != 0) begin
         ph = block_phase + block_step * frames;
         case (wave_reg)
            WAVE_SINE: begin
               idx = (64'(ph[29:0]) * SINE_TABLE_DEPTH + (64'd1 << 29)) >> 30;
               if (idx > SINE_TABLE_DEPTH) idx = SINE_TABLE_DEPTH;
               if (ph[30]) idx = SINE_TABLE_DEPTH - idx;
               w = sine_lut[idx];
               if (ph[31]) w = -w;
            end
            WAVE_TRI: begin
               w = int'(ph >> 15);
               w = (ph < 32'h8000_0000) ? w - 32768 : 98304 - w;
            end
            WAVE_SAW: begin
               if (ph < 32'h4000_0000) begin
                  w = int'(ph >> 14) - 32768;
               end else begin
                  saw_off = ph - 32'h4000_0000;
                  w = 32768 - int'((saw_off + 32'd24576) / 32'd49152);
               end
            end
            default: w = 0;
         endcase
         // Clip the one overflow value at the top of the ramp waves
         if (w > 32767) w = 32767;
         mag    = (w < 0) ? 64'(-w) : 64'(w);
         scaled = (64'(depth_q8) * mag * 64'(gain_q16) + (64'd1 << 30)) >> 31;
         if (scaled > 64'd1048575) scaled = 64'd1048575;
         mag21 = scaled[20:0];
         result.pressure_delta = (w < 0) ? -mag21 : mag21;
      end
      result.phase_now = acc_phase;
      return result;
   endfunction

   // Track settings, predict on each request, compare on each response
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         step_reg    = '0;
         depth_goal  = '0;
         wave_reg    = WAVE_SINE;
         enable_reg  = 1'b0;
         acc_phase   = '0;
         block_phase = '0;
         block_step  = '0;
         gain_q16    = '0;
         depth_q8    = '0;
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PHASE_STEP:   step_reg   = csr_wdata;
               CSR_DEPTH_TARGET: depth_goal = csr_wdata[19:0];
               CSR_WAVE_SELECT:  wave_reg   = csr_wdata[1:0];
               CSR_ENABLE:       enable_reg = csr_wdata[0];
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("response with no item outstanding: pressure_delta %0d phase_now %h",
                      rsp_data.pressure_delta, rsp_data.phase_now);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               results_taken <= results_taken + 1;
               if (rsp_data.pressure_delta !== want.pressure_delta) begin
                  $error("pressure_delta: expected %0d, got %0d",
                         want.pressure_delta, rsp_data.pressure_delta);
                  error_count++;
               end
               if (rsp_data.phase_now !== want.phase_now) begin
                  $error("phase_now: expected %h, got %h", want.phase_now, rsp_data.phase_now);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_results.push_back(modulate_item(req_data));
            items_taken <= items_taken + 1;
         end
      end
   end

endmodule

[test/tremulant_lfo_modulator_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tremulant_lfo_modulator_test: testbench top of the tremulant LFO modulator
// Drives directed corner items (wave peaks, wrap, silent cases, unknown
// waveform) and then randomized advance/query blocks under changing settings
// and flow-control mixes; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tremulant_lfo_modulator_test;
   import tlfo_pkg::*;

   localparam logic [1:0] WAVE_UNUSED    = 2'd3;
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam int         RANDOM_ITEMS   = 1250;
   localparam int         SEGMENTS       = 10;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_ready;
   req_type               req_data       = '0;
   logic                  rsp_valid;
   logic                  rsp_ready      = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid      = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index      = '0;
   logic [CSR_DATA_W-1:0] csr_wdata      = '0;

   int failures;
   int pending;
   int send_gap_pct   = 0;
   int recv_stall_pct = 0;
   int quiet_cycles   = 0;
   int items_sent     = 0;
   int queries_sent   = 0;
   int settings_used  = 0;

   tremulant_lfo_modulator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tremulant_lfo_modulator_checker u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .failures  (failures),
      .pending   (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the response side at the current rate
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Abort when no channel has moved for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tremulant_lfo_modulator verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one item, idling first at the current rate; valid stays up after
   task automatic send_item(input logic act, input logic [FRAME_FIELD_W-1:0] frame);
      req_type item;
      item.action       = act;
      item.frame_number = frame;
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (act == ACT_QUERY) queries_sent++;
   endtask

   // Hold until every predicted response has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Write all four registers once the block is idle
   task automatic load_settings(input logic [31:0] step, input logic [31:0] depth,
                                input logic [31:0] wave, input logic [31:0] en);
      wait_for_results();
      write_reg(CSR_PHASE_STEP, step);
      write_reg(CSR_DEPTH_TARGET, depth);
      write_reg(CSR_WAVE_SELECT, wave);
      write_reg(CSR_ENABLE, en);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   initial begin
      int                       target;
      int                       mode;
      int                       pick;
      int                       burst;
      logic [31:0]              step;
      logic [FRAME_FIELD_W-1:0] span;
      logic [FRAME_FIELD_W-1:0] frame;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Triangle: silent before any ramp, then both peaks and the wrap edge
      load_settings(32'h0001_0000, 32'h000F_FFFF, 32'(WAVE_TRI), 32'd1);
      send_item(ACT_QUERY, 16'd0);
      send_item(ACT_ADVANCE, 16'd0);
      send_item(ACT_QUERY, 16'd0);
      send_item(ACT_QUERY, 16'd32768);
      send_item(ACT_QUERY, 16'd16384);
      send_item(ACT_QUERY, 16'hFFFF);

      // Saw: overflow at the quarter point, then a near-full-cycle advance
      load_settings(32'h0001_0000, 32'h000F_FFFF, 32'(WAVE_SAW), 32'd1);
      send_item(ACT_QUERY, 16'd16384);
      send_item(ACT_QUERY, 16'd0);
      send_item(ACT_QUERY, 16'hFFFF);
      send_item(ACT_ADVANCE, 16'hFFFF);
      send_item(ACT_QUERY, 16'd1);

      // Sine with the largest step, so every product of two or more frames wraps
      load_settings(32'hFFFF_FFFF, 32'h000F_FFFF, 32'(WAVE_SINE), 32'd1);
      send_item(ACT_ADVANCE, 16'hFFFF);
      send_item(ACT_QUERY, 16'd0);
      send_item(ACT_QUERY, 16'd1);
      send_item(ACT_QUERY, 16'hFFFF);
      send_item(ACT_QUERY, 16'd12345);

      // Unknown waveform with the tremulant switched off and zero depth
      load_settings(32'h0000_0000, 32'h0000_0000, 32'(WAVE_UNUSED), 32'd0);
      send_item(ACT_QUERY, 16'd7);
      send_item(ACT_ADVANCE, 16'd100);
      send_item(ACT_QUERY, 16'd100);

      // Random blocks: an advance followed by queries into that block
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         pick = $urandom_range(0, 5);
         step = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF :
                (pick == 2) ? 32'($urandom_range(1, 1 << 20)) : $urandom;
         pick = $urandom_range(0, 7);
         load_settings(step,
                       {12'($urandom), (pick == 0) ? 20'd0 : (pick == 1) ? 20'hFFFFF
                                                   : 20'($urandom)},
                       {30'($urandom), 2'($urandom_range(0, 3))},
                       {31'($urandom), 1'($urandom_range(0, 3) != 0)});
         mode = seg % 4;
         case (mode)
            0: begin send_gap_pct = 0;  recv_stall_pct <= 0;  end
            1: begin send_gap_pct = 67; recv_stall_pct <= 0;  end
            2: begin send_gap_pct = 0;  recv_stall_pct <= 67; end
            default: begin send_gap_pct = 17; recv_stall_pct <= 17; end
         endcase
         target = items_sent + RANDOM_ITEMS / SEGMENTS;
         while (items_sent < target) begin
            pick = $urandom_range(0, 9);
            span = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
                   (pick <= 4) ? 16'($urandom_range(1, 255)) : 16'($urandom);
            send_item(ACT_ADVANCE, span);
            burst = $urandom_range(0, 6);
            for (int q = 0; q < burst; q++) begin
               frame = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, span));
               send_item(ACT_QUERY, frame);
            end
         end
      end

      // Drain and let any stray response show up
      wait_for_results();
      repeat (20) @(posedge clock);
      $display("Covered %0d items (%0d queries) over %0d register settings,", items_sent,
               queries_sent, settings_used);
      $display("with free-running, sender-idle, receiver-stall and mixed flow control.");
      if (failures == 0 && pending == 0) begin
         $display("tremulant_lfo_modulator verification clean");
      end else begin
         $display("tremulant_lfo_modulator verification failed");
      end
      $finish;
   end

endmodule

[files.f]
design/tlfo_pkg.sv
design/tlfo_front.sv
design/tlfo_back.sv
design/tremulant_lfo_modulator.sv
test/tremulant_lfo_modulator_checker.sv
test/tremulant_lfo_modulator_test.sv
